@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the command decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset, on aclk / aresetn
`define OCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define OCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ocd_pkg.sv @@
// ---------------------------------------------------------------------------
// ocd_pkg
// Types, constants and helper functions of the obfuscated command decoder.
// ---------------------------------------------------------------------------
package ocd_pkg;

    localparam int PKT_BYTES   = 20;
    localparam int CNT_W       = $clog2(PKT_BYTES + 1);
    localparam int MEM_DEPTH   = 16;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int SMALL_BYTES = 5;

    localparam logic [CNT_W-1:0] POS_B0    = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_B1    = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_B2    = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_B3    = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_B4    = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_SMALL = CNT_W'(SMALL_BYTES);
    localparam logic [CNT_W-1:0] POS_KEY1  = CNT_W'(16);
    localparam logic [CNT_W-1:0] POS_TAG   = CNT_W'(17);
    localparam logic [CNT_W-1:0] POS_KEY2  = CNT_W'(18);
    localparam logic [CNT_W-1:0] POS_KEY3  = CNT_W'(19);
    localparam logic [CNT_W-1:0] POS_MEM   = CNT_W'(MEM_DEPTH);
    localparam logic [CNT_W-1:0] POS_FULL  = CNT_W'(PKT_BYTES);

    localparam logic [7:0] OP_KEY     = 8'h69;
    localparam logic [7:0] OP_MODE    = 8'h1A;
    localparam logic [7:0] OP_SET_A   = 8'h19;
    localparam logic [7:0] OP_SET_B   = 8'h23;
    localparam logic [7:0] OP_CAM_OFF = 8'h13;
    localparam logic [7:0] OP_CONFIG  = 8'h17;
    localparam logic [7:0] OP_IGNORE  = 8'h12;

    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam logic [2:0] MODE_REPORT = 3'd7;
    localparam logic [2:0] MODE_CAM_ON = 3'd4;
    localparam logic [2:0] MODE_FLAG   = 3'd2;

    typedef enum logic [2:0] {
        ACT_IGNORE,
        ACT_MODE,
        ACT_REPORT,
        ACT_CAM_OFF,
        ACT_SET_REG,
        ACT_CONFIG,
        ACT_UNKNOWN
    } act_t;

    // bytes of one packet kept at fixed places, plus the index captures
    typedef struct packed {
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;
        logic [7:0] s3;
        logic [7:0] s4;
        logic [7:0] s16;
        logic [7:0] s18;
        logic [7:0] s19;
        logic [7:0] cap_m;
        logic [7:0] cap_c;
        logic [7:0] cap_p;
        logic       has17;
    } pkt_t;

    typedef struct packed {
        logic [CNT_W-1:0] m;
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] p;
    } idx_t;

    function automatic logic [3:0] ocd_r2(logic [7:0] b1, logic [7:0] b2,
                                          logic [7:0] b3, logic [7:0] b4);
        return {b1[3], b2[2], b3[1], b4[0]};
    endfunction

    // payload byte positions: r2-1 (clamped at zero), r2, r2+1
    function automatic idx_t ocd_idx(logic [3:0] r2);
        idx_t ix;
        ix.c = CNT_W'(r2);
        ix.m = (r2 == 4'd0) ? '0 : CNT_W'(r2) - CNT_W'(1);
        ix.p = CNT_W'(r2) + CNT_W'(1);
        return ix;
    endfunction

endpackage

@@ hw/rtl/ocd_collect.sv @@
// ---------------------------------------------------------------------------
// ocd_collect
// Packet byte collector: fixed-place byte registers, index captures, a
// 16-byte store for the opcode nibble lookup and the packet hand-off slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ocd_collect (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_last_byte,
    output logic                pkt_valid,
    input  logic                pkt_ready,
    output ocd_pkg::pkt_t       pkt,
    output logic [7:0]          rd_lo,
    output logic [7:0]          rd_hi
);
    import ocd_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    pkt_t             col_reg;
    pkt_t             col_next;
    pkt_t             pkt_reg;
    logic             pkt_valid_reg;
    logic             pkt_valid_next;
    logic [7:0]       rd_lo_reg;
    logic [7:0]       rd_hi_reg;
    logic [7:0]       mem [MEM_DEPTH];
    logic             acc;
    logic             wr_en;
    idx_t             idx;

    assign s_ready = !pkt_valid_reg || pkt_ready;
    assign acc     = s_valid && s_ready;
    assign wr_en   = acc && (cnt_reg < POS_FULL);

    assign pkt_valid_next = (pkt_valid_reg && !pkt_ready) || (acc && s_last_byte);

    always_comb begin
        idx      = ocd_idx(ocd_r2(col_reg.s1, col_reg.s2, col_reg.s3, col_reg.s4));
        col_next = col_reg;
        if (wr_en) begin
            case (cnt_reg)
                POS_B0:   col_next.s0    = s_data_byte;
                POS_B1:   col_next.s1    = s_data_byte;
                POS_B2:   col_next.s2    = s_data_byte;
                POS_B3:   col_next.s3    = s_data_byte;
                POS_B4:   col_next.s4    = s_data_byte;
                POS_KEY1: col_next.s16   = s_data_byte;
                POS_TAG:  col_next.has17 = 1'b1;
                POS_KEY2: col_next.s18   = s_data_byte;
                POS_KEY3: col_next.s19   = s_data_byte;
                default: begin
                end
            endcase
            // bytes 1..4 are complete from position 5 on
            if (cnt_reg >= POS_SMALL) begin
                if (cnt_reg == idx.m) begin
                    col_next.cap_m = s_data_byte;
                end
                if (cnt_reg == idx.c) begin
                    col_next.cap_c = s_data_byte;
                end
                if (cnt_reg == idx.p) begin
                    col_next.cap_p = s_data_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            col_reg       <= '0;
            pkt_valid_reg <= 1'b0;
        end else begin
            pkt_valid_reg <= pkt_valid_next;
            if (acc) begin
                if (s_last_byte) begin
                    cnt_reg <= '0;
                    col_reg <= '0;
                end else begin
                    col_reg <= col_next;
                    if (wr_en) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_last_byte) begin
            pkt_reg <= col_next;
        end
    end

    // bytes 0..15 for the nibble lookup; read once, when byte 17 lands
    always_ff @(posedge aclk) begin
        if (wr_en && (cnt_reg < POS_MEM)) begin
            mem[cnt_reg[MEM_AW-1:0]] <= s_data_byte;
        end
        if (wr_en && (cnt_reg == POS_TAG)) begin
            rd_lo_reg <= mem[s_data_byte[3:0]];
            rd_hi_reg <= mem[s_data_byte[7:4]];
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;
    assign rd_lo     = rd_lo_reg;
    assign rd_hi     = rd_hi_reg;

    `OCD_ASSERT(a_cnt_sat, cnt_reg <= POS_FULL, "byte count past packet size")
    `OCD_ASSERT(a_hold_in, (pkt_valid_reg && !pkt_ready) |-> !s_ready, "beat while slot full")
    `OCD_ASSERT_NEXT(a_clear, acc && s_last_byte, !col_reg.has17 && cnt_reg == '0, "no clear")

endmodule

@@ hw/rtl/ocd_decode.sv @@
// ---------------------------------------------------------------------------
// ocd_decode
// Opcode and argument decode of a collected packet, device mode and camera
// state, and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ocd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  ocd_pkg::pkt_t       pkt,
    input  logic [7:0]          rd_lo,
    input  logic [7:0]          rd_hi,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_opcode,
    output logic [7:0]          m_arg_one,
    output logic [7:0]          m_arg_two,
    output logic [7:0]          m_arg_three,
    output logic [2:0]          m_cmd_length,
    output logic [2:0]          m_action,
    output logic [2:0]          m_mode_now,
    output logic                m_camera_flag,
    output logic                m_report_bit
);
    import ocd_pkg::*;

    idx_t       idx;
    logic [7:0] v_m;
    logic [7:0] v_c;
    logic [7:0] v_p;
    logic [7:0] mix_c;
    logic [7:0] op;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] a3;
    logic [2:0] len;
    act_t       act;
    logic [2:0] mode_next;
    logic       cam_next;
    logic       pkt_fire;

    logic       m_valid_reg;
    logic [2:0] mode_reg;
    logic       cam_reg;
    logic [7:0] opcode_reg;
    logic [7:0] arg_one_reg;
    logic [7:0] arg_two_reg;
    logic [7:0] arg_three_reg;
    logic [2:0] len_reg;
    act_t       act_reg;
    logic       report_reg;

    function automatic logic [7:0] pick(pkt_t p, logic [CNT_W-1:0] ix, logic [7:0] cap);
        logic [7:0] v;
        case (ix)
            POS_B0:  v = p.s0;
            POS_B1:  v = p.s1;
            POS_B2:  v = p.s2;
            POS_B3:  v = p.s3;
            POS_B4:  v = p.s4;
            default: v = cap;
        endcase
        return v;
    endfunction

    assign pkt_ready = !m_valid_reg || m_ready;
    assign pkt_fire  = pkt_valid && pkt_ready;

    always_comb begin
        idx   = ocd_idx(ocd_r2(pkt.s1, pkt.s2, pkt.s3, pkt.s4));
        v_m   = pick(pkt, idx.m, pkt.cap_m);
        v_c   = pick(pkt, idx.c, pkt.cap_c);
        v_p   = pick(pkt, idx.p, pkt.cap_p);
        mix_c = v_c ^ pkt.s16;
        // without byte 17 both nibble picks land on byte 0
        op    = pkt.s0 ^ OP_KEY ^ (pkt.has17 ? (rd_lo ^ rd_hi) : 8'h00);

        a1        = '0;
        a2        = '0;
        a3        = '0;
        len       = LEN_ONE;
        act       = ACT_UNKNOWN;
        mode_next = mode_reg;
        cam_next  = cam_reg;

        case (op)
            OP_MODE: begin
                len = LEN_TWO;
                a1  = {5'b0, mix_c[6:4]};
                if (mix_c[6:4] == MODE_REPORT) begin
                    act = ACT_REPORT;
                end else begin
                    act       = ACT_MODE;
                    mode_next = mix_c[6:4];
                    if (mix_c[6:4] == MODE_CAM_ON) begin
                        cam_next = 1'b1;
                    end
                end
            end
            OP_SET_A, OP_SET_B: begin
                len = LEN_FOUR;
                act = ACT_SET_REG;
                a1  = mix_c;
                a2  = v_m ^ pkt.s19;
                a3  = v_p ^ pkt.s18;
            end
            OP_IGNORE: begin
                act = ACT_IGNORE;
            end
            OP_CAM_OFF: begin
                act      = ACT_CAM_OFF;
                cam_next = 1'b0;
            end
            OP_CONFIG: begin
                act = ACT_CONFIG;
            end
            default: begin
                act = ACT_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            mode_reg    <= '0;
            cam_reg     <= 1'b0;
        end else begin
            if (pkt_fire) begin
                m_valid_reg <= 1'b1;
                mode_reg    <= mode_next;
                cam_reg     <= cam_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pkt_fire) begin
            opcode_reg    <= op;
            arg_one_reg   <= a1;
            arg_two_reg   <= a2;
            arg_three_reg <= a3;
            len_reg       <= len;
            act_reg       <= act;
            report_reg    <= (mode_next > MODE_FLAG);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_opcode      = opcode_reg;
    assign m_arg_one     = arg_one_reg;
    assign m_arg_two     = arg_two_reg;
    assign m_arg_three   = arg_three_reg;
    assign m_cmd_length  = len_reg;
    assign m_action      = act_reg;
    assign m_mode_now    = mode_reg;
    assign m_camera_flag = cam_reg;
    assign m_report_bit  = report_reg;

    `OCD_ASSERT(a_mode_range, mode_reg != MODE_REPORT, "device mode out of range")
    `OCD_ASSERT(a_mode_op, m_valid_reg && act_reg == ACT_MODE |-> opcode_reg == OP_MODE, "bad mode")
    `OCD_ASSERT_NEXT(a_fire_load, pkt_fire, m_valid_reg, "result not loaded")

endmodule

@@ hw/rtl/obfuscated_command_decoder.sv @@
// ---------------------------------------------------------------------------
// obfuscated_command_decoder
// Collects a host command packet byte by byte and decodes the hidden command.
// ---------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_      | in  | s_valid / s_ready | s_data_byte, s_last_byte
//  m_      | out | m_valid / m_ready | m_opcode, m_arg_*, m_cmd_length, m_action,
//          |     |                   | m_mode_now, m_camera_flag, m_report_bit
//
// One byte beat per cycle while s_ready is high. A packet's result passes
// from its last beat into the packet slot, then through decode to the result
// register. Synchronous reset clears the byte count, collected bytes, mode
// and camera flag. With m_ready low one result waits in the result register
// and one in the packet slot; only then does s_ready drop.
// ---------------------------------------------------------------------------
module obfuscated_command_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_opcode,
    output logic [7:0]  m_arg_one,
    output logic [7:0]  m_arg_two,
    output logic [7:0]  m_arg_three,
    output logic [2:0]  m_cmd_length,
    output logic [2:0]  m_action,
    output logic [2:0]  m_mode_now,
    output logic        m_camera_flag,
    output logic        m_report_bit
);
    import ocd_pkg::*;

    pkt_t       pkt;
    logic       pkt_valid;
    logic       pkt_ready;
    logic [7:0] rd_lo;
    logic [7:0] rd_hi;

    ocd_collect u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .pkt_valid   (pkt_valid),
        .pkt_ready   (pkt_ready),
        .pkt         (pkt),
        .rd_lo       (rd_lo),
        .rd_hi       (rd_hi)
    );

    ocd_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pkt_valid     (pkt_valid),
        .pkt_ready     (pkt_ready),
        .pkt           (pkt),
        .rd_lo         (rd_lo),
        .rd_hi         (rd_hi),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_opcode      (m_opcode),
        .m_arg_one     (m_arg_one),
        .m_arg_two     (m_arg_two),
        .m_arg_three   (m_arg_three),
        .m_cmd_length  (m_cmd_length),
        .m_action      (m_action),
        .m_mode_now    (m_mode_now),
        .m_camera_flag (m_camera_flag),
        .m_report_bit  (m_report_bit)
    );

endmodule

@@ sim/ocd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_checker
// Watches both channels of the command decoder. It keeps its own copy of the
// packet bytes, mode and camera flag, and decodes each packet on its last
// beat. Each result beat is compared field by field with the oldest decoded
// command. The failure count and the number of results still due go to the
// testbench top.
// ----------------------------------------------------------------------------
module ocd_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_opcode,
    input  logic [7:0] m_arg_one,
    input  logic [7:0] m_arg_two,
    input  logic [7:0] m_arg_three,
    input  logic [2:0] m_cmd_length,
    input  logic [2:0] m_action,
    input  logic [2:0] m_mode_now,
    input  logic       m_camera_flag,
    input  logic       m_report_bit,
    output int         fails,
    output int         pending
);
    import ocd_pkg::*;

    typedef struct {
        logic [7:0] opcode;
        logic [7:0] arg_one;
        logic [7:0] arg_two;
        logic [7:0] arg_three;
        logic [2:0] cmd_length;
        act_t       action;
        logic [2:0] mode_now;
        logic       camera_flag;
        logic       report_bit;
    } decoded_cmd_t;

    logic [7:0]   pkt_mem [PKT_BYTES];
    int           pkt_cnt;
    logic [2:0]   dev_mode;
    logic         cam_on;
    decoded_cmd_t cmd_due [$];
    decoded_cmd_t head;

    initial begin
        fails   = 0;
        pending = 0;
    end

    // bytes not sent in this packet are still zero from the last clear
    function automatic logic [7:0] stored(input int idx);
        return (idx < PKT_BYTES) ? pkt_mem[idx] : 8'h00;
    endfunction

    function automatic void clear_packet();
        foreach (pkt_mem[i]) pkt_mem[i] = 8'h00;
        pkt_cnt = 0;
    endfunction

    task automatic report(input string msg);
        $display("ocd_checker: %0t ns: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report($sformatf("%s is %02h, expected %02h", name, got, want));
        end
    endtask

    task automatic absorb_byte(input logic [7:0] data, input logic last);
        logic [7:0]   tag;
        logic [7:0]   op;
        logic [7:0]   key;
        logic [7:0]   b1, b2, b3, b4;
        logic [3:0]   r2;
        decoded_cmd_t res;
        if (pkt_cnt < PKT_BYTES) begin
            pkt_mem[pkt_cnt] = data;
            pkt_cnt++;
        end
        if (last) begin
            tag = stored(17);
            op  = stored(0) ^ stored(tag[3:0]) ^ stored(tag[7:4]) ^ OP_KEY;
            b1  = stored(1);
            b2  = stored(2);
            b3  = stored(3);
            b4  = stored(4);
            r2  = {b1[3], b2[2], b3[1], b4[0]};
            key = stored(r2) ^ stored(16);

            res.opcode     = op;
            res.arg_one    = 8'h00;
            res.arg_two    = 8'h00;
            res.arg_three  = 8'h00;
            res.cmd_length = LEN_ONE;
            case (op)
                OP_MODE: begin
                    res.cmd_length = LEN_TWO;
                    res.arg_one    = {5'd0, key[6:4]};
                    if (key[6:4] == MODE_REPORT) begin
                        res.action = ACT_REPORT;
                    end else begin
                        res.action = ACT_MODE;
                        dev_mode   = key[6:4];
                        if (key[6:4] == MODE_CAM_ON) cam_on = 1'b1;
                    end
                end
                OP_SET_A, OP_SET_B: begin
                    res.cmd_length = LEN_FOUR;
                    res.action     = ACT_SET_REG;
                    res.arg_one    = key;
                    // index below zero clamps to byte 0
                    res.arg_two    = stored((r2 == 4'd0) ? 0 : int'(r2) - 1) ^ stored(19);
                    res.arg_three  = stored(int'(r2) + 1) ^ stored(18);
                end
                OP_IGNORE:  res.action = ACT_IGNORE;
                OP_CAM_OFF: begin
                    res.action = ACT_CAM_OFF;
                    cam_on     = 1'b0;
                end
                OP_CONFIG:  res.action = ACT_CONFIG;
                default:    res.action = ACT_UNKNOWN;
            endcase
            res.mode_now    = dev_mode;
            res.camera_flag = cam_on;
            res.report_bit  = (dev_mode > MODE_FLAG);
            cmd_due.push_back(res);
            clear_packet();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_packet();
            dev_mode = 3'd0;
            cam_on   = 1'b0;
            cmd_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (cmd_due.size() == 0) begin
                    report("result beat with no command pending");
                end else begin
                    head = cmd_due.pop_front();
                    check_field("opcode", m_opcode, head.opcode);
                    check_field("arg_one", m_arg_one, head.arg_one);
                    check_field("arg_two", m_arg_two, head.arg_two);
                    check_field("arg_three", m_arg_three, head.arg_three);
                    check_field("cmd_length", m_cmd_length, head.cmd_length);
                    check_field("action", m_action, head.action);
                    check_field("mode_now", m_mode_now, head.mode_now);
                    check_field("camera_flag", m_camera_flag, head.camera_flag);
                    check_field("report_bit", m_report_bit, head.report_bit);
                end
            end
            if (s_valid && s_ready) absorb_byte(s_data_byte, s_last_byte);
        end
        pending <= cmd_due.size();
    end

endmodule

@@ sim/obfuscated_command_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfuscated_command_decoder_tb
// Sends command packets byte by byte into the decoder: first single-byte and
// short packets that reach every opcode, then random packets built to decode
// to chosen opcodes and modes, mixed with short, overlong and noise packets.
// Both channels stall at random. The checker does all result comparison.
// ----------------------------------------------------------------------------
module obfuscated_command_decoder_tb;
    import ocd_pkg::*;

    localparam int BYTE_TARGET = 1050;
    localparam int IDLE_LIMIT  = 4000;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_last_byte = 1'b0;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_opcode, m_arg_one, m_arg_two, m_arg_three;
    logic [2:0] m_cmd_length, m_action, m_mode_now;
    logic       m_camera_flag, m_report_bit;

    int         fails;
    int         pending;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    int         bytes_sent  = 0;
    bit         calm        = 1'b0;
    logic [7:0] frame [32];
    int         frame_len;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    obfuscated_command_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_opcode     (m_opcode),
        .m_arg_one    (m_arg_one),
        .m_arg_two    (m_arg_two),
        .m_arg_three  (m_arg_three),
        .m_cmd_length (m_cmd_length),
        .m_action     (m_action),
        .m_mode_now   (m_mode_now),
        .m_camera_flag(m_camera_flag),
        .m_report_bit (m_report_bit)
    );

    ocd_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_opcode     (m_opcode),
        .m_arg_one    (m_arg_one),
        .m_arg_two    (m_arg_two),
        .m_arg_three  (m_arg_three),
        .m_cmd_length (m_cmd_length),
        .m_action     (m_action),
        .m_mode_now   (m_mode_now),
        .m_camera_flag(m_camera_flag),
        .m_report_bit (m_report_bit),
        .fails        (fails),
        .pending      (pending)
    );

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_beat(input logic [7:0] data, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_len; i++) send_beat(frame[i], i == frame_len - 1);
    endtask

    task automatic one_byte(input logic [7:0] b);
        frame[0]  = b;
        frame_len = 1;
        send_frame();
    endtask

    // hold the sender off until every decoded command has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // random packet; when steered, one byte that feeds the opcode XOR an odd
    // number of times is patched so the packet decodes to want, and with pin_mode
    // set and byte 16 present, byte 16 is patched so a mode command lands on mode_sel
    task automatic make_command(input bit steer, input logic [7:0] want, input int len,
                                input bit pin_mode, input logic [2:0] mode_sel);
        int         n1, n2, fix;
        logic [7:0] cur;
        logic [3:0] r2;
        for (int i = 0; i < 32; i++) frame[i] = (i < len) ? 8'($urandom) : 8'h00;
        frame_len = len;
        if (steer) begin
            n1  = (len > 17) ? int'(frame[17][3:0]) : 0;
            n2  = (len > 17) ? int'(frame[17][7:4]) : 0;
            cur = frame[0] ^ frame[n1] ^ frame[n2] ^ OP_KEY;
            if ((n1 == 0) != (n2 == 0)) fix = (n1 == 0) ? n2 : n1;
            else fix = 0;
            frame[fix] = frame[fix] ^ cur ^ want;
            if (pin_mode && len >= 17) begin
                r2 = {frame[1][3], frame[2][2], frame[3][1], frame[4][0]};
                frame[16] = frame[r2] ^ {1'($urandom), mode_sel, 4'($urandom)};
            end
        end
    endtask

    initial begin
        int         r;
        int         len;
        bit         steer;
        logic [7:0] want;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-byte packets: opcode is byte 0 ^ key, payload index clamps at 0
        one_byte(8'h00);
        one_byte(8'hFF);
        one_byte(OP_IGNORE ^ OP_KEY);
        one_byte(OP_CONFIG ^ OP_KEY);
        one_byte(OP_SET_A ^ OP_KEY);
        one_byte(OP_SET_B ^ OP_KEY);
        one_byte(OP_MODE ^ OP_KEY);
        // short mode packet selecting byte 1 for mode 4, camera on
        frame[0]  = OP_MODE ^ OP_KEY;
        frame[1]  = 8'h40;
        frame[2]  = 8'h00;
        frame[3]  = 8'h00;
        frame[4]  = 8'h01;
        frame_len = 5;
        send_frame();
        one_byte(OP_CAM_OFF ^ OP_KEY);
        drain();

        while (bytes_sent < BYTE_TARGET) begin
            calm = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 50) len = 20;
            else if (r < 65) len = $urandom_range(21, 26);
            else len = $urandom_range(1, 19);

            r     = $urandom_range(0, 99);
            steer = (r >= 10);
            if (r < 35) want = OP_MODE;
            else if (r < 50) want = OP_SET_A;
            else if (r < 62) want = OP_SET_B;
            else if (r < 70) want = OP_CAM_OFF;
            else if (r < 78) want = OP_CONFIG;
            else if (r < 86) want = OP_IGNORE;
            else want = 8'($urandom);

            make_command(steer, want, len, $urandom_range(0, 3) != 0,
                         3'($urandom_range(0, 7)));
            send_frame();
            if ($urandom_range(0, 14) == 0) drain();
        end
        calm = 1'b0;

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
